### rtl/hsc_pkg.sv
`timescale 1ns / 1ps
// Package for the Hamming SEC codec: widths, register indexes, result struct
// and the bit placement helpers. No dependencies.
package hsc_pkg;

  localparam int DW_W        = 57;   // max message bits
  localparam int CW_W        = 63;   // max codeword positions
  localparam int SYN_W       = 6;
  localparam int CNT_W       = 3;
  localparam int LEN_W       = 6;
  localparam int IN_TDATA_W  = 120;
  localparam int RES_W       = CW_W + DW_W + SYN_W + 2 + CNT_W;
  localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_ADDR_W-1:0] CFG_DATA_LEN   = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ODD_PARITY = 1'b1;

  localparam logic [LEN_W-1:0] DATA_LEN_RST = 6'd4;
  localparam logic [LEN_W-1:0] DATA_LEN_MAX = LEN_W'(DW_W);

  typedef enum logic {
    REQ_ENCODE = 1'b0,
    REQ_DECODE = 1'b1
  } req_type_e;

  typedef struct packed {
    logic [CNT_W-1:0] check_count;
    logic             beyond_length;
    logic             error_seen;
    logic [SYN_W-1:0] syndrome;
    logic [DW_W-1:0]  data_out;
    logic [CW_W-1:0]  code_out;
  } hsc_result_t;

  // Message bit k goes to the k-th position that is not a power of two.
  function automatic logic [CW_W-1:0] scatter_data(input logic [DW_W-1:0] d);
    logic [CW_W-1:0] cw;
    logic [5:0]      k;
    cw = '0;
    k  = '0;
    for (int p = 1; p <= CW_W; p++) begin
      if ((p & (p - 1)) != 0) begin
        cw[p-1] = d[k];
        k       = k + 6'd1;
      end
    end
    return cw;
  endfunction

  function automatic logic [DW_W-1:0] gather_data(input logic [CW_W-1:0] cw);
    logic [DW_W-1:0] d;
    logic [5:0]      k;
    d = '0;
    k = '0;
    for (int p = 1; p <= CW_W; p++) begin
      if ((p & (p - 1)) != 0) begin
        d[k] = cw[p-1];
        k    = k + 6'd1;
      end
    end
    return d;
  endfunction

  // Positions whose index has bit i set.
  function automatic logic [CW_W-1:0] cover_mask(input int i);
    logic [CW_W-1:0] m;
    m = '0;
    for (int p = 1; p <= CW_W; p++) begin
      m[p-1] = ((p >> i) & 1) != 0;
    end
    return m;
  endfunction

  // Smallest r with n + r + 1 <= 2^r.
  function automatic logic [CNT_W-1:0] check_bits(input logic [LEN_W-1:0] n);
    logic [CNT_W-1:0] r;
    r = 3'd1;
    for (int j = 0; j < SYN_W; j++) begin
      if (r < 3'd6 && ({2'b0, n} + {5'b0, r} + 8'd1) > (8'd1 << r)) begin
        r = r + 3'd1;
      end
    end
    return r;
  endfunction

endpackage

### rtl/hsc_core.sv
`timescale 1ns / 1ps
// Combinational encode / decode-and-correct of one word.
// Depends on hsc_pkg.
module hsc_core (
  input  logic                       req_type_i,
  input  logic [hsc_pkg::DW_W-1:0]   data_word_i,
  input  logic [hsc_pkg::CW_W-1:0]   code_word_i,
  input  logic [hsc_pkg::LEN_W-1:0]  data_len_i,
  input  logic                       odd_parity_i,
  output hsc_pkg::hsc_result_t       result_o
);
  import hsc_pkg::*;

  logic [LEN_W-1:0] n_eff;
  logic [CNT_W-1:0] r;
  logic [LEN_W-1:0] len;
  logic [CW_W-1:0]  lmask;
  logic [CW_W-1:0]  enc_base;
  logic [CW_W-1:0]  cw_enc;
  logic [CW_W-1:0]  cw_rx;
  logic [CW_W-1:0]  cw_dec;
  logic [CW_W-1:0]  cw_out;
  logic [SYN_W-1:0] syn;
  logic             beyond;

  always_comb begin
    if (data_len_i == '0) begin
      n_eff = 6'd1;
    end else if (data_len_i > DATA_LEN_MAX) begin
      n_eff = DATA_LEN_MAX;
    end else begin
      n_eff = data_len_i;
    end
    r     = check_bits(n_eff);
    len   = n_eff + {3'b0, r};
    lmask = ~({CW_W{1'b1}} << len);
  end

  // encode
  always_comb begin
    enc_base = scatter_data(data_word_i) & lmask;
    cw_enc   = enc_base;
    for (int i = 0; i < SYN_W; i++) begin
      if (3'(i) < r) begin
        cw_enc[(1 << i) - 1] = odd_parity_i ^ (^(enc_base & cover_mask(i)));
      end
    end
  end

  // decode
  always_comb begin
    cw_rx = code_word_i & lmask;
    for (int i = 0; i < SYN_W; i++) begin
      syn[i] = (3'(i) < r) & (odd_parity_i ^ (^(cw_rx & cover_mask(i))));
    end
    beyond = 1'b0;
    cw_dec = cw_rx;
    if (syn != '0) begin
      if (syn <= len) begin
        cw_dec = cw_rx ^ ({{(CW_W-1){1'b0}}, 1'b1} << (syn - 6'd1));
      end else begin
        beyond = 1'b1;
      end
    end
  end

  always_comb begin
    if (req_type_e'(req_type_i) == REQ_DECODE) begin
      cw_out                 = cw_dec;
      result_o.syndrome      = syn;
      result_o.error_seen    = syn != '0;
      result_o.beyond_length = beyond;
    end else begin
      cw_out                 = cw_enc;
      result_o.syndrome      = '0;
      result_o.error_seen    = 1'b0;
      result_o.beyond_length = 1'b0;
    end
    result_o.code_out    = cw_out;
    result_o.data_out    = gather_data(cw_out);
    result_o.check_count = r;
  end

endmodule

### rtl/hamming_sec_codec_top.sv
`timescale 1ns / 1ps
// Top level of the Hamming SEC codec: stream ports, config registers, pipeline.
// Depends on hsc_pkg and hsc_core.
//
// Single-error-correcting Hamming encoder/decoder for 1 to 57 message bits
// (data_len, values above 57 act as 57, zero acts as 1) with even or odd
// parity. Each transaction passes an input register, then a result register,
// before its result is valid on the master side; one word is taken per cycle
// while the master side does not stall. Backpressure on the master side stalls
// both stages. Change the configuration only while no transaction is in flight.
module hamming_sec_codec_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [hsc_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [hsc_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [56:0] data_word, [119:57] code_word
  input  logic [hsc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // [0] req_type
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [62:0] code_out, [119:63] data_out, [125:120] syndrome, [126] error_seen,
  // [127] beyond_length, [130:128] check_count, [135:131] zero
  output logic [hsc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import hsc_pkg::*;

  logic [LEN_W-1:0] data_len_q;
  logic             odd_parity_q;

  logic             s1_valid_q;
  logic             req_q;
  logic [DW_W-1:0]  data_q;
  logic [CW_W-1:0]  code_q;

  logic             s2_valid_q;
  hsc_result_t      result_d;
  hsc_result_t      result_q;

  logic             s2_ready;
  logic             s1_ready;
  logic             s1_load;
  logic             s2_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_len_q   <= DATA_LEN_RST;
      odd_parity_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_DATA_LEN:   data_len_q   <= cfg_wdata_i;
        CFG_ODD_PARITY: odd_parity_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign s2_ready      = !s2_valid_q || m_axis_tready;
  assign s1_ready      = !s1_valid_q || s2_ready;
  assign s1_load       = s_axis_tvalid && s1_ready;
  assign s2_load       = s1_valid_q && s2_ready;
  assign s_axis_tready = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= s_axis_tvalid;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      req_q  <= s_axis_tuser;
      data_q <= s_axis_tdata[DW_W-1:0];
      code_q <= s_axis_tdata[DW_W+CW_W-1:DW_W];
    end
    if (s2_load) begin
      result_q <= result_d;
    end
  end

  hsc_core u_core (
    .req_type_i   (req_q),
    .data_word_i  (data_q),
    .code_word_i  (code_q),
    .data_len_i   (data_len_q),
    .odd_parity_i (odd_parity_q),
    .result_o     (result_d)
  );

  assign m_axis_tvalid = s2_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-RES_W){1'b0}}, result_q};

endmodule

### rtl/hsc_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the Hamming SEC codec, bound to the top level.
// Depends on hsc_pkg and hamming_sec_codec_top.
module hsc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [hsc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import hsc_pkg::*;

  hsc_result_t res;
  assign res = m_axis_tdata[RES_W-1:0];

  // stalled result stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_err_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> res.error_seen == (res.syndrome != '0))
    else $error("error_seen does not match syndrome");

  a_beyond: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.beyond_length |-> res.error_seen)
    else $error("beyond_length without error");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> res.check_count != '0 && res.check_count <= 3'd6)
    else $error("check_count out of range");

endmodule

bind hamming_sec_codec_top hsc_checker u_hsc_checker (.*);

### dv/tb.sv
`timescale 1ns / 1ps
// Testbench for hamming_sec_codec_top: directed rows, then random encode/decode
// traffic with random stalls on both streams, checked against a local predictor.
// Depends on hsc_pkg and the codec RTL.
module tb;
  import hsc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 125;
  localparam logic [DW_W-1:0] MSG_ONES = '1;
  localparam logic [CW_W-1:0] CW_ONES = '1;
  localparam logic [CW_W-1:0] CW_TOP = {1'b1, {(CW_W-1){1'b0}}};

  typedef struct {
    logic [LEN_W-1:0] len;
    logic             odd;
    req_type_e        req;
    logic [DW_W-1:0]  msg;
    logic [CW_W-1:0]  rx;
    bit               typed;
    hsc_result_t      res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // side info that travels with the item on the input stream
  bit          cur_typed = 1'b0;
  hsc_result_t cur_res = '0;

  logic [LEN_W-1:0] cfg_len = DATA_LEN_RST;
  logic             cfg_odd = 1'b0;
  bit               quiet = 1'b0;
  hsc_result_t      pending_results[$];
  hsc_result_t      got, want;
  int unsigned      errors = 0;
  int unsigned      cycles = 0;
  int               stall_left = 0;
  stim_row_t        rows [24];

  hamming_sec_codec_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Hamming SEC encode / decode for the given register values.
  function automatic hsc_result_t codec_result(input logic [LEN_W-1:0] len_reg,
                                               input logic odd, input req_type_e req,
                                               input logic [DW_W-1:0] msg,
                                               input logic [CW_W-1:0] rx);
    int n, r, last, k, syn, x;
    logic [CW_W-1:0] cw;
    logic [DW_W-1:0] d;
    logic par;
    hsc_result_t res;
    n = len_reg;
    if (n < 1) n = 1;
    if (n > DW_W) n = DW_W;
    r = 1;
    while (r < 7 && n + r + 1 > (1 << r)) r++;
    last = n + r;
    cw = '0;
    syn = 0;
    if (req == REQ_ENCODE) begin
      k = 0;
      for (int p = 1; p <= last; p++) begin
        if ((p & (p - 1)) != 0) begin
          cw[p-1] = msg[k];
          k++;
        end
      end
      for (int i = 0; i < r; i++) begin
        x = 1 << i;
        par = odd;
        for (int p = 1; p <= last; p++) begin
          if ((p & x) != 0 && p != x) par ^= cw[p-1];
        end
        cw[x-1] = par;
      end
    end else begin
      for (int p = 1; p <= last; p++) cw[p-1] = rx[p-1];
      for (int i = 0; i < r; i++) begin
        x = 1 << i;
        par = odd;
        for (int p = 1; p <= last; p++) begin
          if ((p & x) != 0) par ^= cw[p-1];
        end
        if (par) syn |= x;
      end
      if (syn != 0 && syn <= last) cw[syn-1] = ~cw[syn-1];
    end
    d = '0;
    k = 0;
    for (int p = 1; p <= last; p++) begin
      if ((p & (p - 1)) != 0) begin
        d[k] = cw[p-1];
        k++;
      end
    end
    res.code_out = cw;
    res.data_out = d;
    res.syndrome = syn[SYN_W-1:0];
    res.error_seen = syn != 0;
    res.beyond_length = syn > last;
    res.check_count = r[CNT_W-1:0];
    return res;
  endfunction

  function automatic hsc_result_t res_of(input logic [CW_W-1:0] code,
                                         input logic [DW_W-1:0] data,
                                         input logic [SYN_W-1:0] syn, input logic beyond,
                                         input logic [CNT_W-1:0] cnt);
    hsc_result_t res;
    res.code_out = code;
    res.data_out = data;
    res.syndrome = syn;
    res.error_seen = syn != 0;
    res.beyond_length = beyond;
    res.check_count = cnt;
    return res;
  endfunction

  function automatic logic [CW_W-1:0] rand_word();
    return CW_W'({$urandom, $urandom});
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %h got %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // input acceptance first, then output check, so ordering within the edge is fixed
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (cur_typed) pending_results.push_back(cur_res);
        else pending_results.push_back(codec_result(cfg_len, cfg_odd,
            req_type_e'(s_axis_tuser), s_axis_tdata[DW_W-1:0],
            s_axis_tdata[IN_TDATA_W-1:DW_W]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = hsc_result_t'(m_axis_tdata[RES_W-1:0]);
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result expected none got %h", $time, got);
          errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("code_out", 64'(want.code_out), 64'(got.code_out));
          check_field("data_out", 64'(want.data_out), 64'(got.data_out));
          check_field("syndrome", 64'(want.syndrome), 64'(got.syndrome));
          check_field("error_seen", 64'(want.error_seen), 64'(got.error_seen));
          check_field("beyond_length", 64'(want.beyond_length), 64'(got.beyond_length));
          check_field("check_count", 64'(want.check_count), 64'(got.check_count));
        end
        stall_left = quiet ? 0 : $urandom_range(0, 4);
        m_axis_tready <= (stall_left == 0);
      end else if (stall_left > 0) begin
        stall_left = stall_left - 1;
        m_axis_tready <= (stall_left == 0);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  task automatic send_item(input req_type_e req, input logic [DW_W-1:0] msg,
                           input logic [CW_W-1:0] rx, input bit typed,
                           input hsc_result_t res);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {rx, msg};
    s_axis_tuser <= req;
    cur_typed <= typed;
    cur_res <= res;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic apply_config(input logic [LEN_W-1:0] len, input logic odd);
    wait_idle();
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= CFG_DATA_LEN;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_addr_i <= CFG_ODD_PARITY;
    cfg_wdata_i <= CFG_DATA_W'(odd);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_len = len;
    cfg_odd = odd;
  endtask

  initial begin
    req_type_e        req;
    logic [DW_W-1:0]  msg;
    logic [CW_W-1:0]  rx;
    logic [LEN_W-1:0] len;
    logic             odd;
    int               kind;
    hsc_result_t      enc;

    rows = '{
      '{6'd4, 1'b0, REQ_ENCODE, 57'h0, 63'h0, 1'b1, res_of(63'h0, 57'h0, 6'd0, 1'b0, 3'd3)},
      '{6'd4, 1'b0, REQ_ENCODE, MSG_ONES, 63'h0, 1'b1,
        res_of(63'h7f, 57'hf, 6'd0, 1'b0, 3'd3)},
      '{6'd4, 1'b0, REQ_DECODE, 57'h0, 63'h0, 1'b1, res_of(63'h0, 57'h0, 6'd0, 1'b0, 3'd3)},
      '{6'd4, 1'b0, REQ_DECODE, 57'h0, CW_ONES, 1'b1,
        res_of(63'h7f, 57'hf, 6'd0, 1'b0, 3'd3)},
      '{6'd4, 1'b0, REQ_DECODE, MSG_ONES, 63'h10, 1'b1,
        res_of(63'h0, 57'h0, 6'd5, 1'b0, 3'd3)},
      '{6'd4, 1'b0, REQ_DECODE, 57'h0, CW_TOP, 1'b1, res_of(63'h0, 57'h0, 6'd0, 1'b0, 3'd3)},
      '{6'd4, 1'b1, REQ_ENCODE, 57'h0, 63'h0, 1'b1, res_of(63'hb, 57'h0, 6'd0, 1'b0, 3'd3)},
      '{6'd4, 1'b1, REQ_DECODE, 57'h0, 63'h0, 1'b1, res_of(63'h40, 57'h8, 6'd7, 1'b0, 3'd3)},
      '{6'd4, 1'b1, REQ_ENCODE, 57'h5, CW_ONES, 1'b0, '0},
      '{6'd2, 1'b0, REQ_DECODE, 57'h0, 63'ha, 1'b1, res_of(63'ha, 57'h0, 6'd6, 1'b1, 3'd3)},
      '{6'd2, 1'b0, REQ_DECODE, 57'h0, 63'hb, 1'b1, res_of(63'hb, 57'h0, 6'd7, 1'b1, 3'd3)},
      '{6'd2, 1'b1, REQ_DECODE, 57'h0, 63'h15, 1'b0, '0},
      '{6'd0, 1'b0, REQ_ENCODE, MSG_ONES, 63'h0, 1'b1, res_of(63'h7, 57'h1, 6'd0, 1'b0, 3'd2)},
      '{6'd0, 1'b0, REQ_DECODE, 57'h0, 63'h4, 1'b1, res_of(63'h0, 57'h0, 6'd3, 1'b0, 3'd2)},
      '{6'd57, 1'b0, REQ_ENCODE, MSG_ONES, 63'h0, 1'b1,
        res_of(CW_ONES, MSG_ONES, 6'd0, 1'b0, 3'd6)},
      '{6'd57, 1'b0, REQ_DECODE, 57'h0, CW_ONES, 1'b1,
        res_of(CW_ONES, MSG_ONES, 6'd0, 1'b0, 3'd6)},
      '{6'd57, 1'b0, REQ_DECODE, 57'h0, CW_TOP, 1'b1,
        res_of(63'h0, 57'h0, 6'd63, 1'b0, 3'd6)},
      '{6'd57, 1'b1, REQ_ENCODE, 57'h0, 63'h0, 1'b0, '0},
      '{6'd57, 1'b1, REQ_DECODE, 57'h0, 63'h2aaa_aaaa_aaaa_aaaa, 1'b0, '0},
      '{6'd63, 1'b0, REQ_ENCODE, MSG_ONES, 63'h0, 1'b1,
        res_of(CW_ONES, MSG_ONES, 6'd0, 1'b0, 3'd6)},
      '{6'd63, 1'b1, REQ_DECODE, 57'h0, 63'h0, 1'b0, '0},
      '{6'd1, 1'b1, REQ_ENCODE, 57'h1, 63'h0, 1'b0, '0},
      '{6'd3, 1'b0, REQ_DECODE, MSG_ONES, CW_ONES, 1'b0, '0},
      '{6'd3, 1'b1, REQ_ENCODE, MSG_ONES, CW_ONES, 1'b0, '0}
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].len != cfg_len || rows[i].odd != cfg_odd)
        apply_config(rows[i].len, rows[i].odd);
      send_item(rows[i].req, rows[i].msg, rows[i].rx, rows[i].typed, rows[i].res);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: len = 6'd57;
        1: len = 6'd0;
        2: len = 6'd63;
        3: len = 6'd1;
        4: len = 6'd2;
        default: len = LEN_W'($urandom_range(0, 63));
      endcase
      odd = (ph < 4) ? ph[0] : 1'($urandom_range(0, 1));
      apply_config(len, odd);
      quiet = (ph % 4 == 3);
      for (int j = 0; j < PHASE_ITEMS; j++) begin
        if (ph == 5 && j == PHASE_ITEMS / 2) wait_idle();
        req = req_type_e'($urandom_range(0, 1));
        msg = DW_W'(rand_word());
        rx = rand_word();
        if (req == REQ_DECODE) begin
          kind = $urandom_range(0, 9);
          if (kind <= 5) begin
            enc = codec_result(cfg_len, cfg_odd, REQ_ENCODE, msg, '0);
            rx = enc.code_out;
            if (kind >= 2) rx[$urandom_range(0, CW_W - 1)] ^= 1'b1;
            if (kind == 5) rx[$urandom_range(0, CW_W - 1)] ^= 1'b1;
          end
        end
        send_item(req, msg, rx, 1'b0, '0);
      end
    end
    quiet = 1'b0;

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (errors == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

endmodule

### filelist.f
rtl/hsc_pkg.sv
rtl/hsc_core.sv
rtl/hamming_sec_codec_top.sv
rtl/hsc_checker.sv
dv/tb.sv
